FILE: rtl/vzd_pkg.sv
// Shared types and constants for the varint / zigzag decoder.
// Used by the front, back, top level and checker; no dependencies.
package vzd_pkg;

  // Field widths fixed by the stream format
  localparam int unsigned ByteW    = 8;
  localparam int unsigned GroupW   = 7;
  localparam int unsigned ValueW   = 64;
  localparam int unsigned CountW   = 4;
  localparam int unsigned IdxW     = 4;
  localparam int unsigned ShamtW   = 6;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned ContBit  = 7;
  localparam int unsigned OutDataW = 72;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_EARLY_END = 2'd1,
    ST_TOO_LONG  = 2'd2
  } status_e;

  // One classified byte as it travels from front to back
  typedef struct packed {
    logic [GroupW-1:0] payload;   // low seven bits of the byte
    logic [IdxW-1:0]   idx;       // position of the byte within its value
    logic              terminal;  // this byte closes the value
    status_e           status;    // outcome when terminal
  } entry_t;

endpackage

FILE: rtl/varint_zigzag_decoder.sv
// Base-128 varint decoder with optional zigzag undo, one byte per transfer.
// Path from byte transfer to result transfer: the queue, then the output register.
// Throughput: one byte per cycle while the output accepts results; set by the single accumulator
// merge in the back end, which retires one queued byte each cycle.
// Reset (rst_ni low, async): queue and accumulator empty, signed_mode = 0.
// Depends on vzd_pkg, vzd_front, vzd_fifo and vzd_back.
module varint_zigzag_decoder #(
  parameter int unsigned MAX_LEN     = 10,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration: signed_mode
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  // Input stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [vzd_pkg::ByteW-1:0]     s_axis_tdata_i,  // [7:0] data_byte
  input  logic                          s_axis_tlast_i,  // end_of_buffer
  // Output stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [vzd_pkg::OutDataW-1:0]  m_axis_tdata_o,  // [63:0] value,
                                                          // [67:64] byte_count,
                                                          // [71:68] zero
  output logic [vzd_pkg::StatusW-1:0]   m_axis_tuser_o   // [1:0] status
);

  localparam int unsigned EntryW = $bits(vzd_pkg::entry_t);

  logic                        signed_mode_q;
  logic                        push_valid, push_ready, pop_valid, pop_ready;
  vzd_pkg::entry_t             push_entry, pop_entry;
  logic [EntryW-1:0]           pop_bits;
  logic [vzd_pkg::ValueW-1:0]  out_value;
  logic [vzd_pkg::CountW-1:0]  out_count;
  vzd_pkg::status_e            out_status;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      signed_mode_q <= cfg_wdata_i;
    end
  end

  // Front end: classify bytes
  vzd_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid_i),
    .s_ready_o    (s_axis_tready_o),
    .s_byte_i     (s_axis_tdata_i),
    .s_last_i     (s_axis_tlast_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  // Queue between front and back
  vzd_fifo #(
    .WIDTH (EntryW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_bits)
  );

  assign pop_entry = vzd_pkg::entry_t'(pop_bits);

  // Back end: accumulate and emit
  vzd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .signed_mode_i (signed_mode_q),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_entry_i   (pop_entry),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_value_o   (out_value),
    .out_count_o   (out_count),
    .out_status_o  (out_status)
  );

  assign m_axis_tdata_o = {4'b0000, out_count, out_value};
  assign m_axis_tuser_o = out_status;

endmodule

FILE: rtl/vzd_front.sv
// Front end: accepts encoded bytes, tracks the byte position and classifies
// each byte as continue, ok, early end or too long. Depends on vzd_pkg.
module vzd_front #(
  parameter int unsigned MAX_LEN = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_valid_i,
  output logic                       s_ready_o,
  input  logic [vzd_pkg::ByteW-1:0]  s_byte_i,
  input  logic                       s_last_i,
  output logic                       push_valid_o,
  input  logic                       push_ready_i,
  output vzd_pkg::entry_t            push_entry_o
);

  localparam logic [vzd_pkg::IdxW-1:0] LastIdx = vzd_pkg::IdxW'(MAX_LEN - 1);

  logic [vzd_pkg::IdxW-1:0] idx_q, idx_d;
  logic                     accept;
  vzd_pkg::entry_t          entry;

  assign s_ready_o    = push_ready_i;
  assign push_valid_o = s_valid_i;
  assign accept       = s_valid_i && push_ready_i;

  // Classification: a final byte wins, then early end, then too long
  always_comb begin
    entry.payload  = s_byte_i[vzd_pkg::GroupW-1:0];
    entry.idx      = idx_q;
    entry.terminal = 1'b1;
    entry.status   = vzd_pkg::ST_OK;
    priority if (!s_byte_i[vzd_pkg::ContBit]) begin
      entry.status = vzd_pkg::ST_OK;
    end else if (s_last_i) begin
      entry.status = vzd_pkg::ST_EARLY_END;
    end else if (idx_q >= LastIdx) begin
      entry.status = vzd_pkg::ST_TOO_LONG;
    end else begin
      entry.terminal = 1'b0;
    end
  end

  assign push_entry_o = entry;

  // Byte position counter, restarts after every result
  always_comb begin
    idx_d = idx_q;
    if (accept) begin
      idx_d = entry.terminal ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

FILE: rtl/vzd_fifo.sv
// Short register queue between the front and back ends of the decoder.
// Generic width and depth; no package dependency.
module vzd_fifo #(
  parameter int unsigned WIDTH = 13,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CntW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/vzd_back.sv
// Back end: merges payload groups into the accumulator, applies zigzag undo
// and holds the result in an output register. Depends on vzd_pkg.
module vzd_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         signed_mode_i,
  input  logic                         pop_valid_i,
  output logic                         pop_ready_o,
  input  vzd_pkg::entry_t              pop_entry_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [vzd_pkg::ValueW-1:0]   out_value_o,
  output logic [vzd_pkg::CountW-1:0]   out_count_o,
  output vzd_pkg::status_e             out_status_o
);

  logic [vzd_pkg::ValueW-1:0]  acc_q, acc_d;
  logic [vzd_pkg::ValueW-1:0]  merged, zz;
  logic [vzd_pkg::ShamtW-1:0]  shamt;
  logic                        out_free, pop, load;
  logic                        out_valid_q, out_valid_d;
  logic [vzd_pkg::ValueW-1:0]  value_q, value_d;
  logic [vzd_pkg::CountW-1:0]  count_q, count_d;
  vzd_pkg::status_e            status_q, status_d;

  assign out_free    = !out_valid_q || out_ready_i;
  assign pop_ready_o = !pop_entry_i.terminal || out_free;
  assign pop         = pop_valid_i && pop_ready_o;
  assign load        = pop && pop_entry_i.terminal;

  // Place the payload group at bit 7 * idx; bits past 63 fall off
  assign shamt  = vzd_pkg::ShamtW'(vzd_pkg::ShamtW'(pop_entry_i.idx) *
                                   vzd_pkg::ShamtW'(vzd_pkg::GroupW));
  assign merged = acc_q | (vzd_pkg::ValueW'(pop_entry_i.payload) << shamt);

  // Zigzag undo: (u >> 1) ^ -(u & 1)
  assign zz = (merged >> 1) ^ {vzd_pkg::ValueW{merged[0]}};

  // Accumulator: cleared after any result
  always_comb begin
    acc_d = acc_q;
    if (pop) begin
      acc_d = pop_entry_i.terminal ? '0 : merged;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    value_d     = value_q;
    count_d     = count_q;
    status_d    = status_q;
    if (load) begin
      out_valid_d = 1'b1;
      count_d     = vzd_pkg::CountW'(pop_entry_i.idx) + 1'b1;
      status_d    = pop_entry_i.status;
      if (pop_entry_i.status == vzd_pkg::ST_OK) begin
        value_d = signed_mode_i ? zz : merged;
      end else begin
        value_d = '0;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q  <= value_d;
    count_q  <= count_d;
    status_q <= status_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = value_q;
  assign out_count_o  = count_q;
  assign out_status_o = status_q;

endmodule

FILE: rtl/vzd_checker.sv
// Port-level checker for the varint decoder, bound to the top level.
// Depends on vzd_pkg and varint_zigzag_decoder.
module vzd_checker #(
  parameter int unsigned MAX_LEN = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  input  logic [vzd_pkg::OutDataW-1:0]  m_axis_tdata_o,
  input  logic [vzd_pkg::StatusW-1:0]   m_axis_tuser_o
);

  localparam logic [vzd_pkg::CountW-1:0] MaxCnt = vzd_pkg::CountW'(MAX_LEN);

  // A stalled result transfer holds its contents
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("output changed while stalled");

  // Byte count stays within one to the length limit
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[67:64] != '0 && m_axis_tdata_o[67:64] <= MaxCnt)
    else $error("byte count out of range");

  // Error results carry a zero value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != vzd_pkg::ST_OK |-> m_axis_tdata_o[63:0] == '0)
    else $error("error result with nonzero value");

  // Too-long results always report the full length
  a_long_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == vzd_pkg::ST_TOO_LONG |->
      m_axis_tdata_o[67:64] == MaxCnt)
    else $error("too-long result with short count");

  // Status stays within the defined codes, padding stays zero
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      m_axis_tuser_o <= vzd_pkg::ST_TOO_LONG && m_axis_tdata_o[71:68] == '0)
    else $error("bad status code or padding");

endmodule

bind varint_zigzag_decoder vzd_checker #(
  .MAX_LEN (MAX_LEN)
) u_vzd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
